[design/categorical_naive_bayes_classifier_unit_defines.svh]
// Assertion macros shared by the classifier RTL.
`ifndef CATEGORICAL_NAIVE_BAYES_CLASSIFIER_UNIT_DEFINES_SVH
`define CATEGORICAL_NAIVE_BAYES_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define CNBC_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("cnbc: same-cycle check failed");

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define CNBC_ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("cnbc: next-cycle check failed");

`endif

[design/cnbc_pkg.sv]
// Shared constants, codes and types of the naive Bayes classifier.
package cnbc_pkg;

    localparam int NUM_CLASSES    = 8;
    localparam int CLASS_W        = 3;
    localparam int NUM_FEATURES   = 8;
    localparam int FIDX_W         = 3;
    localparam int FEAT_W         = 4;
    localparam int SCORE_W        = 17;
    localparam int ONE_FIX        = 65536;
    localparam int FRAC_W         = 16;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int NUM_VALUES_DEF  = 16;

    localparam logic [1:0] MODE_CLEAR   = 2'd0;
    localparam logic [1:0] MODE_TRAIN   = 2'd1;
    localparam logic [1:0] MODE_PREDICT = 2'd2;
    localparam logic [1:0] MODE_PROBS   = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLR,
        S_TR_RD,
        S_TR_WR,
        S_TR_FIN,
        S_SC_NEXT,
        S_SC_RD,
        S_SC_CNT,
        S_SC_DIV,
        S_SC_PRI,
        S_SC_DIV2,
        S_SC_DONE,
        S_SC_END,
        S_NM_EMIT,
        S_BEST_EMIT,
        S_PR_NEXT,
        S_PR_DIV,
        S_PR_EMIT,
        S_FIN
    } state_t;

    // Control strobes broadcast along the row of class cells.
    typedef struct packed {
        logic wr;
        logic wr_all;
        logic inc;
        logic clr;
    } cell_ctl_t;

endpackage

[design/cnbc_cell.sv]
// One class cell: value-count memory, class count and the read chain link.
module cnbc_cell #(
    parameter int IDX         = 0,
    parameter int COUNT_WIDTH = cnbc_pkg::COUNT_WIDTH_DEF,
    parameter int AW          = 7
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cnbc_pkg::cell_ctl_t          ctl,
    input  logic [cnbc_pkg::CLASS_W-1:0] sel_cls,
    input  logic [AW-1:0]                addr,
    input  logic [COUNT_WIDTH-1:0]       wr_data,
    input  logic [COUNT_WIDTH-1:0]       rd_in,
    input  logic [COUNT_WIDTH-1:0]       cnt_in,
    output logic [COUNT_WIDTH-1:0]       rd_out,
    output logic [COUNT_WIDTH-1:0]       cnt_out,
    output logic                         present
);
    import cnbc_pkg::*;

    logic [COUNT_WIDTH-1:0] mem [2**AW];
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic [COUNT_WIDTH-1:0] cnt_reg;
    logic [COUNT_WIDTH-1:0] cnt_next;
    logic                   hit;

    assign hit = (sel_cls == CLASS_W'(IDX));

    // Value-count memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (ctl.wr && (ctl.wr_all || hit))
        begin
            mem[addr] <= wr_data;
        end
        rd_data_reg <= mem[addr];
    end

    // Class count: cleared as a whole, bumped with saturation.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctl.clr)
        begin
            cnt_next = '0;
        end
        else if (ctl.inc && hit && (cnt_reg != '1))
        begin
            cnt_next = cnt_reg + COUNT_WIDTH'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // The selected cell puts its data on the chain; the others pass it on.
    assign rd_out  = hit ? rd_data_reg : rd_in;
    assign cnt_out = hit ? cnt_reg : cnt_in;
    assign present = (cnt_reg != '0);

endmodule

[design/cnbc_div.sv]
// Restoring divider that produces one quotient bit per cycle.
module cnbc_div #(
    parameter int DW = 33
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [DW-1:0] quo,
    output logic          done
);
    import cnbc_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] rem_reg;
    logic [DW-1:0] quo_reg;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          busy_reg;
    logic          busy_next;
    logic          done_reg;
    logic          done_next;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic          ge;

    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = (shifted >= {1'b0, den_reg});

    // Iteration counter and completion pulse.
    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next  = CW'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Shift-subtract datapath.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DW-1:0] : shifted[DW-1:0];
            quo_reg <= {quo_reg[DW-2:0], ge};
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

[design/categorical_naive_bayes_classifier_unit.sv]
// Top level: categorical naive Bayes classifier over a row of class cells.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in      | input     | in_valid / in_stall  | mode, update, label, feature_0..feature_7
//  out     | output    | out_valid / out_stall| class_id, score, is_winner, is_last,
//          |           |                      | no_model, zero_sum
//
// One transaction at a time. Clear sweeps all NUM_FEATURES*2^clog2(NUM_VALUES) words
// (128 by default) of the cell memories; reset runs the same sweep first.
// Train reads and rewrites the count of each in-range feature value, then bumps the
// class count. Predict runs up to NUM_CLASSES*(NUM_FEATURES+1) divisions on the shared
// divider that yields one quotient bit per cycle (DW = 33 by default); probs adds up to
// NUM_CLASSES more divisions. A stalled output holds the sequencer in its emit state.
`include "categorical_naive_bayes_classifier_unit_defines.svh"

module categorical_naive_bayes_classifier_unit #(
    parameter int COUNT_WIDTH = cnbc_pkg::COUNT_WIDTH_DEF,
    parameter int NUM_VALUES  = cnbc_pkg::NUM_VALUES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   mode,
    input  logic                         update,
    input  logic [cnbc_pkg::CLASS_W-1:0] label,
    input  logic [cnbc_pkg::FEAT_W-1:0]  feature_0,
    input  logic [cnbc_pkg::FEAT_W-1:0]  feature_1,
    input  logic [cnbc_pkg::FEAT_W-1:0]  feature_2,
    input  logic [cnbc_pkg::FEAT_W-1:0]  feature_3,
    input  logic [cnbc_pkg::FEAT_W-1:0]  feature_4,
    input  logic [cnbc_pkg::FEAT_W-1:0]  feature_5,
    input  logic [cnbc_pkg::FEAT_W-1:0]  feature_6,
    input  logic [cnbc_pkg::FEAT_W-1:0]  feature_7,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [cnbc_pkg::CLASS_W-1:0] class_id,
    output logic [cnbc_pkg::SCORE_W-1:0] score,
    output logic                         is_winner,
    output logic                         is_last,
    output logic                         no_model,
    output logic                         zero_sum
);
    import cnbc_pkg::*;

    localparam int VB    = $clog2(NUM_VALUES);
    localparam int AW    = FIDX_W + VB;
    localparam int SWEEP = 2**AW;
    localparam int SUM_W = SCORE_W + CLASS_W;
    localparam int PW    = SCORE_W + COUNT_WIDTH;
    localparam int DW    = (PW > SCORE_W + FRAC_W) ? PW : SCORE_W + FRAC_W;

    // Sequencer state and working registers.
    state_t                 state_reg, state_next;
    logic [AW-1:0]          clr_addr_reg, clr_addr_next;
    logic [COUNT_WIDTH-1:0] total_reg, total_next;
    logic                   out_valid_reg, out_valid_next;
    logic [FEAT_W-1:0]      feat_reg [NUM_FEATURES];
    logic [FEAT_W-1:0]      feat_in  [NUM_FEATURES];
    logic [1:0]             mode_reg;
    logic                   upd_reg;
    logic [CLASS_W-1:0]     cls_reg, cls_next;
    logic [FIDX_W-1:0]      f_reg, f_next;
    logic [SCORE_W-1:0]     s_reg, s_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [CLASS_W-1:0]     best_reg, best_next;
    logic [SCORE_W-1:0]     best_val_reg, best_val_next;
    logic [CLASS_W-1:0]     last_reg, last_next;
    logic                   any_reg, any_next;
    logic [SCORE_W-1:0]     scores_reg [NUM_CLASSES];
    logic                   score_wr;

    // Output register.
    logic [CLASS_W-1:0]     class_id_reg, class_id_next;
    logic [SCORE_W-1:0]     score_reg, score_next;
    logic                   win_reg, win_next;
    logic                   last_o_reg, last_o_next;
    logic                   nm_reg, nm_next;
    logic                   zs_reg, zs_next;

    // Cell row and divider connections.
    cell_ctl_t              ctl;
    logic [AW-1:0]          addr;
    logic [COUNT_WIDTH-1:0] wr_data;
    logic [COUNT_WIDTH-1:0] rd_chain  [NUM_CLASSES+1];
    logic [COUNT_WIDTH-1:0] cnt_chain [NUM_CLASSES+1];
    logic [NUM_CLASSES-1:0] present;
    logic [COUNT_WIDTH-1:0] rd;
    logic [COUNT_WIDTH-1:0] prior;
    logic [COUNT_WIDTH-1:0] mul_b;
    logic [PW-1:0]          prod;
    logic                   div_start;
    logic [DW-1:0]          div_num;
    logic [DW-1:0]          div_den;
    logic [DW-1:0]          div_quo;
    logic                   div_done;
    logic [FEAT_W-1:0]      cur_v;
    logic                   v_ok;
    logic [VB-1:0]          vidx;
    logic                   accept;
    logic                   out_free;

    assign feat_in[0] = feature_0;
    assign feat_in[1] = feature_1;
    assign feat_in[2] = feature_2;
    assign feat_in[3] = feature_3;
    assign feat_in[4] = feature_4;
    assign feat_in[5] = feature_5;
    assign feat_in[6] = feature_6;
    assign feat_in[7] = feature_7;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Current feature value and its memory address.
    assign cur_v = feat_reg[f_reg];
    assign v_ok  = (32'(cur_v) < 32'(NUM_VALUES));
    assign vidx  = VB'(cur_v);
    assign addr  = (state_reg == S_CLR) ? clr_addr_reg : {f_reg, vidx};

    // Row of class cells; the selected cell drives the end of the chain.
    assign rd_chain[0]  = '0;
    assign cnt_chain[0] = '0;

    for (genvar i = 0; i < NUM_CLASSES; i++)
    begin : g_cell
        cnbc_cell #(
            .IDX         (i),
            .COUNT_WIDTH (COUNT_WIDTH),
            .AW          (AW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .sel_cls (cls_reg),
            .addr    (addr),
            .wr_data (wr_data),
            .rd_in   (rd_chain[i]),
            .cnt_in  (cnt_chain[i]),
            .rd_out  (rd_chain[i+1]),
            .cnt_out (cnt_chain[i+1]),
            .present (present[i])
        );
    end

    assign rd    = rd_chain[NUM_CLASSES];
    assign prior = cnt_chain[NUM_CLASSES];

    // Score times count or prior, ahead of the divider.
    assign mul_b = (state_reg == S_SC_CNT) ? rd : prior;
    assign prod  = {{COUNT_WIDTH{1'b0}}, s_reg} * {{SCORE_W{1'b0}}, mul_b};

    cnbc_div #(
        .DW (DW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .done  (div_done)
    );

    // Sequencer: next state, datapath control and output loading.
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        total_next     = total_reg;
        cls_next       = cls_reg;
        f_next         = f_reg;
        s_next         = s_reg;
        sum_next       = sum_reg;
        best_next      = best_reg;
        best_val_next  = best_val_reg;
        last_next      = last_reg;
        any_next       = any_reg;
        score_wr       = 1'b0;
        ctl            = '0;
        wr_data        = '0;
        div_start      = 1'b0;
        div_num        = DW'(prod);
        div_den        = DW'(prior);
        out_valid_next = out_valid_reg && out_stall;
        class_id_next  = class_id_reg;
        score_next     = score_reg;
        win_next       = win_reg;
        last_o_next    = last_o_reg;
        nm_next        = nm_reg;
        zs_next        = zs_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (mode) inside
                        MODE_CLEAR:
                        begin
                            ctl.clr       = 1'b1;
                            total_next    = '0;
                            clr_addr_next = '0;
                            state_next    = S_CLR;
                        end
                        MODE_TRAIN:
                        begin
                            cls_next   = label;
                            f_next     = '0;
                            state_next = S_TR_RD;
                        end
                        MODE_PREDICT, MODE_PROBS:
                        begin
                            cls_next      = '0;
                            sum_next      = '0;
                            best_next     = '0;
                            best_val_next = '0;
                            last_next     = '0;
                            any_next      = 1'b0;
                            state_next    = S_SC_NEXT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CLR:
            begin
                ctl.wr        = 1'b1;
                ctl.wr_all    = 1'b1;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(SWEEP - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_TR_RD:
            begin
                if (v_ok)
                begin
                    state_next = S_TR_WR;
                end
                else if (f_reg == FIDX_W'(NUM_FEATURES - 1))
                begin
                    state_next = S_TR_FIN;
                end
                else
                begin
                    f_next = f_reg + FIDX_W'(1);
                end
            end
            S_TR_WR:
            begin
                ctl.wr  = 1'b1;
                wr_data = (rd == '1) ? rd : rd + COUNT_WIDTH'(1);
                if (f_reg == FIDX_W'(NUM_FEATURES - 1))
                begin
                    state_next = S_TR_FIN;
                end
                else
                begin
                    f_next     = f_reg + FIDX_W'(1);
                    state_next = S_TR_RD;
                end
            end
            S_TR_FIN:
            begin
                ctl.inc    = 1'b1;
                total_next = (total_reg == '1) ? total_reg : total_reg + COUNT_WIDTH'(1);
                state_next = S_IDLE;
            end
            S_SC_NEXT:
            begin
                if (present[cls_reg])
                begin
                    f_next = '0;
                    if (total_reg == '0)
                    begin
                        s_next     = '0;
                        state_next = S_SC_DONE;
                    end
                    else
                    begin
                        s_next     = SCORE_W'(ONE_FIX);
                        state_next = S_SC_RD;
                    end
                end
                else
                begin
                    s_next   = '0;
                    score_wr = 1'b1;
                    if (cls_reg == CLASS_W'(NUM_CLASSES - 1))
                    begin
                        state_next = S_SC_END;
                    end
                    else
                    begin
                        cls_next = cls_reg + CLASS_W'(1);
                    end
                end
            end
            S_SC_RD:
            begin
                state_next = S_SC_CNT;
            end
            S_SC_CNT:
            begin
                if (!v_ok || (rd == '0))
                begin
                    s_next     = '0;
                    state_next = S_SC_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_SC_DIV;
                end
            end
            S_SC_DIV:
            begin
                if (div_done)
                begin
                    s_next = div_quo[SCORE_W-1:0];
                    if (f_reg == FIDX_W'(NUM_FEATURES - 1))
                    begin
                        state_next = S_SC_PRI;
                    end
                    else
                    begin
                        f_next     = f_reg + FIDX_W'(1);
                        state_next = S_SC_RD;
                    end
                end
            end
            S_SC_PRI:
            begin
                div_start  = 1'b1;
                div_den    = DW'(total_reg);
                state_next = S_SC_DIV2;
            end
            S_SC_DIV2:
            begin
                if (div_done)
                begin
                    s_next     = div_quo[SCORE_W-1:0];
                    state_next = S_SC_DONE;
                end
            end
            S_SC_DONE:
            begin
                score_wr = 1'b1;
                sum_next = sum_reg + SUM_W'(s_reg);
                if (!any_reg || (s_reg > best_val_reg))
                begin
                    best_next     = cls_reg;
                    best_val_next = s_reg;
                end
                any_next  = 1'b1;
                last_next = cls_reg;
                if (cls_reg == CLASS_W'(NUM_CLASSES - 1))
                begin
                    state_next = S_SC_END;
                end
                else
                begin
                    cls_next   = cls_reg + CLASS_W'(1);
                    state_next = S_SC_NEXT;
                end
            end
            S_SC_END:
            begin
                if (!any_reg)
                begin
                    state_next = S_NM_EMIT;
                end
                else if (mode_reg == MODE_PREDICT)
                begin
                    state_next = S_BEST_EMIT;
                end
                else
                begin
                    cls_next   = '0;
                    state_next = S_PR_NEXT;
                end
            end
            S_NM_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    class_id_next  = '0;
                    score_next     = '0;
                    win_next       = 1'b0;
                    last_o_next    = 1'b1;
                    nm_next        = 1'b1;
                    zs_next        = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            S_BEST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    class_id_next  = best_reg;
                    score_next     = best_val_reg;
                    win_next       = 1'b1;
                    last_o_next    = 1'b1;
                    nm_next        = 1'b0;
                    zs_next        = 1'b0;
                    state_next     = S_FIN;
                end
            end
            S_PR_NEXT:
            begin
                if (present[cls_reg])
                begin
                    if (sum_reg != '0)
                    begin
                        div_start  = 1'b1;
                        div_num    = DW'({scores_reg[cls_reg], {FRAC_W{1'b0}}});
                        div_den    = DW'(sum_reg);
                        state_next = S_PR_DIV;
                    end
                    else
                    begin
                        s_next     = '0;
                        state_next = S_PR_EMIT;
                    end
                end
                else
                begin
                    cls_next = cls_reg + CLASS_W'(1);
                end
            end
            S_PR_DIV:
            begin
                if (div_done)
                begin
                    s_next     = div_quo[SCORE_W-1:0];
                    state_next = S_PR_EMIT;
                end
            end
            S_PR_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    class_id_next  = cls_reg;
                    score_next     = s_reg;
                    win_next       = (cls_reg == best_reg);
                    last_o_next    = (cls_reg == last_reg);
                    nm_next        = 1'b0;
                    zs_next        = (sum_reg == '0);
                    if (cls_reg == last_reg)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cls_next   = cls_reg + CLASS_W'(1);
                        state_next = S_PR_NEXT;
                    end
                end
            end
            S_FIN:
            begin
                if (upd_reg)
                begin
                    cls_next   = best_reg;
                    f_next     = '0;
                    state_next = S_TR_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers; reset starts the memory sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_addr_reg  <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            feat_reg <= feat_in;
            mode_reg <= mode;
            upd_reg  <= update;
        end
        if (score_wr)
        begin
            scores_reg[cls_reg] <= s_reg;
        end
        cls_reg       <= cls_next;
        f_reg         <= f_next;
        s_reg         <= s_next;
        sum_reg       <= sum_next;
        best_reg      <= best_next;
        best_val_reg  <= best_val_next;
        last_reg      <= last_next;
        any_reg       <= any_next;
        class_id_reg  <= class_id_next;
        score_reg     <= score_next;
        win_reg       <= win_next;
        last_o_reg    <= last_o_next;
        nm_reg        <= nm_next;
        zs_reg        <= zs_next;
    end

    assign out_valid = out_valid_reg;
    assign class_id  = class_id_reg;
    assign score     = score_reg;
    assign is_winner = win_reg;
    assign is_last   = last_o_reg;
    assign no_model  = nm_reg;
    assign zero_sum  = zs_reg;

    // A quotient only completes while the sequencer waits for it.
    `CNBC_ASSERT_IMP(a_div_wait, div_done,
        (state_reg == S_SC_DIV) || (state_reg == S_SC_DIV2) || (state_reg == S_PR_DIV))
    // An accepted transaction keeps the input stalled in the next cycle.
    `CNBC_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    // Scores never exceed one.
    `CNBC_ASSERT_IMP(a_score_range, out_valid, score <= SCORE_W'(ONE_FIX))
    // An empty model gives a single empty result.
    `CNBC_ASSERT_IMP(a_no_model_shape, out_valid && no_model,
        is_last && !is_winner && (score == '0) && !zero_sum)

endmodule

[tb/sv/tb_categorical_naive_bayes_classifier_unit.sv]
// Self-checking testbench for the categorical naive Bayes classifier unit.
`timescale 1ns / 100ps

module tb_categorical_naive_bayes_classifier_unit;
    import cnbc_pkg::*;

    localparam int CNT_MAX = 65535;

    typedef struct {
        logic [1:0] mode;
        logic       update;
        logic [2:0] label;
        logic [3:0] feat [NUM_FEATURES];
    } sample_t;

    typedef struct packed {
        logic [2:0]  class_id;
        logic [16:0] score;
        logic        is_winner;
        logic        is_last;
        logic        no_model;
        logic        zero_sum;
    } verdict_t;

    // Directed row: a sample plus an optional typed-in expected verdict.
    typedef struct {
        sample_t  smp;
        bit       has_fixed;
        verdict_t fixed;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  mode;
    logic        update;
    logic [2:0]  label;
    logic [3:0]  feature_0, feature_1, feature_2, feature_3;
    logic [3:0]  feature_4, feature_5, feature_6, feature_7;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  class_id;
    logic [16:0] score;
    logic        is_winner;
    logic        is_last;
    logic        no_model;
    logic        zero_sum;

    // Shadow of the trained counts.
    int unsigned value_tally [NUM_CLASSES][NUM_FEATURES][16];
    int unsigned class_tally [NUM_CLASSES];
    int unsigned sample_sum;

    verdict_t verdict_q [$];
    int       errors;
    int       send_idle_pct;
    int       recv_idle_pct;
    int       hold_off_cycles;

    categorical_naive_bayes_classifier_unit dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .update(update), .label(label),
        .feature_0(feature_0), .feature_1(feature_1), .feature_2(feature_2),
        .feature_3(feature_3), .feature_4(feature_4), .feature_5(feature_5),
        .feature_6(feature_6), .feature_7(feature_7),
        .out_valid(out_valid), .out_stall(out_stall), .class_id(class_id),
        .score(score), .is_winner(is_winner), .is_last(is_last),
        .no_model(no_model), .zero_sum(zero_sum)
    );

    // Clock generation.
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int unsigned sat_up(int unsigned x);
        return (x >= CNT_MAX) ? CNT_MAX : x + 1;
    endfunction

    function automatic void wipe_counts();
        foreach (value_tally[c, f, v]) value_tally[c][f][v] = 0;
        foreach (class_tally[c]) class_tally[c] = 0;
        sample_sum = 0;
    endfunction

    // Appends one expected verdict to the scoreboard queue.
    function automatic void enqueue_verdict(verdict_t v);
        verdict_q.insert(verdict_q.size(), v);
    endfunction

    function automatic void learn_sample(int unsigned cls, sample_t s);
        for (int f = 0; f < NUM_FEATURES; f++)
            value_tally[cls][f][s.feat[f]] = sat_up(value_tally[cls][f][s.feat[f]]);
        class_tally[cls] = sat_up(class_tally[cls]);
        sample_sum = sat_up(sample_sum);
    endfunction

    function automatic longint unsigned likelihood(int unsigned cls, sample_t s);
        longint unsigned acc;
        longint unsigned prior;
        acc = ONE_FIX;
        prior = class_tally[cls];
        if (prior == 0 || sample_sum == 0)
            return 0;
        for (int f = 0; f < NUM_FEATURES; f++)
        begin
            if (value_tally[cls][f][s.feat[f]] == 0)
                return 0;
            acc = (acc * value_tally[cls][f][s.feat[f]]) / prior;
        end
        return (acc * prior) / sample_sum;
    endfunction

    // Applies one sample to the shadow counts and queues its verdicts.
    function automatic void classify_and_learn(sample_t s);
        longint unsigned lik [NUM_CLASSES];
        longint unsigned total, best_val;
        int unsigned best, last_cls;
        bit any;
        verdict_t v;
        total = 0;
        best_val = 0;
        best = 0;
        last_cls = 0;
        any = 0;
        if (s.mode == MODE_CLEAR)
        begin
            wipe_counts();
            return;
        end
        if (s.mode == MODE_TRAIN)
        begin
            learn_sample(s.label, s);
            return;
        end
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            lik[c] = 0;
            if (class_tally[c] == 0)
                continue;
            lik[c] = likelihood(c, s);
            total += lik[c];
            if (!any || lik[c] > best_val)
            begin
                best = c;
                best_val = lik[c];
            end
            any = 1;
            last_cls = c;
        end
        if (!any)
        begin
            v = '{3'd0, 17'd0, 1'b0, 1'b1, 1'b1, 1'b0};
            enqueue_verdict(v);
            return;
        end
        if (s.mode == MODE_PREDICT)
        begin
            v = '{best[2:0], best_val[16:0], 1'b1, 1'b1, 1'b0, 1'b0};
            enqueue_verdict(v);
        end
        else
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                if (class_tally[c] == 0)
                    continue;
                v.class_id = c[2:0];
                v.score = (total != 0) ? 17'((lik[c] * ONE_FIX) / total) : 17'd0;
                v.is_winner = (c == best);
                v.is_last = (c == last_cls);
                v.no_model = 1'b0;
                v.zero_sum = (total == 0);
                enqueue_verdict(v);
            end
        end
        if (s.update)
            learn_sample(best, s);
    endfunction

    function automatic sample_t make_sample(logic [1:0] md, logic up, logic [2:0] lb,
                                            logic [3:0] fill);
        sample_t s;
        s.mode = md;
        s.update = up;
        s.label = lb;
        foreach (s.feat[f]) s.feat[f] = fill;
        return s;
    endfunction

    // Random sample; features mostly come from a narrow range to keep counts nonzero.
    function automatic sample_t random_sample(int train_pct);
        sample_t s;
        int r;
        r = $urandom_range(99);
        if (r < train_pct)
            s.mode = MODE_TRAIN;
        else if (r < 97)
            s.mode = ($urandom_range(1) != 0) ? MODE_PREDICT : MODE_PROBS;
        else
            s.mode = MODE_CLEAR;
        s.update = 1'($urandom_range(1));
        s.label = 3'($urandom_range(7));
        foreach (s.feat[f])
            s.feat[f] = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                                  : 4'($urandom_range(1) + 2 * (s.label & 1));
        return s;
    endfunction

    // Offers one transaction and waits until it is accepted.
    task automatic send_sample(sample_t s);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= s.mode;
        update <= s.update;
        label <= s.label;
        feature_0 <= s.feat[0];
        feature_1 <= s.feat[1];
        feature_2 <= s.feat[2];
        feature_3 <= s.feat[3];
        feature_4 <= s.feat[4];
        feature_5 <= s.feat[5];
        feature_6 <= s.feat[6];
        feature_7 <= s.feat[7];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        classify_and_learn(s);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // Receiver stall pattern, with an optional long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
    end

    // Output checker.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("unexpected result class_id=%0d score=%0d", class_id, score);
                errors++;
            end
            else
            begin
                verdict_t e;
                e = verdict_q.pop_front();
                if (class_id !== e.class_id)
                begin
                    $error("class_id expected %0d actual %0d", e.class_id, class_id);
                    errors++;
                end
                if (score !== e.score)
                begin
                    $error("score expected %0d actual %0d", e.score, score);
                    errors++;
                end
                if (is_winner !== e.is_winner)
                begin
                    $error("is_winner expected %0d actual %0d", e.is_winner, is_winner);
                    errors++;
                end
                if (is_last !== e.is_last)
                begin
                    $error("is_last expected %0d actual %0d", e.is_last, is_last);
                    errors++;
                end
                if (no_model !== e.no_model)
                begin
                    $error("no_model expected %0d actual %0d", e.no_model, no_model);
                    errors++;
                end
                if (zero_sum !== e.zero_sum)
                begin
                    $error("zero_sum expected %0d actual %0d", e.zero_sum, zero_sum);
                    errors++;
                end
            end
        end
    end

    // Main stimulus.
    initial
    begin
        row_t rows [$];
        row_t rw;
        verdict_t nm;
        verdict_t got;
        errors = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = MODE_CLEAR;
        update = 1'b0;
        label = '0;
        {feature_0, feature_1, feature_2, feature_3} = '0;
        {feature_4, feature_5, feature_6, feature_7} = '0;
        wipe_counts();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        nm = '{3'd0, 17'd0, 1'b0, 1'b1, 1'b1, 1'b0};
        // Directed table: empty model, training, extremes, tie, zero sum, clear.
        rw.has_fixed = 1;
        rw.fixed = nm;
        rw.smp = make_sample(MODE_PREDICT, 1'b1, 3'd0, 4'd0);
        rows.insert(rows.size(), rw);
        rw.smp = make_sample(MODE_PROBS, 1'b1, 3'd7, 4'd15);
        rows.insert(rows.size(), rw);
        rw.has_fixed = 0;
        rw.smp = make_sample(MODE_TRAIN, 1'b1, 3'd0, 4'd0);
        rows.insert(rows.size(), rw);
        // A single trained class scores exactly one.
        rw.has_fixed = 1;
        rw.fixed = '{3'd0, 17'd65536, 1'b1, 1'b1, 1'b0, 1'b0};
        rw.smp = make_sample(MODE_PREDICT, 1'b0, 3'd5, 4'd0);
        rows.insert(rows.size(), rw);
        rw.fixed = '{3'd0, 17'd65536, 1'b1, 1'b1, 1'b0, 1'b0};
        rw.smp = make_sample(MODE_PROBS, 1'b0, 3'd0, 4'd0);
        rows.insert(rows.size(), rw);
        rw.has_fixed = 0;
        rw.smp = make_sample(MODE_TRAIN, 1'b0, 3'd7, 4'd15);
        rows.insert(rows.size(), rw);
        rw.smp = make_sample(MODE_TRAIN, 1'b0, 3'd7, 4'd0);
        rows.insert(rows.size(), rw);
        rw.smp = make_sample(MODE_PREDICT, 1'b0, 3'd0, 4'd0);
        rows.insert(rows.size(), rw);
        rw.smp = make_sample(MODE_PROBS, 1'b0, 3'd0, 4'd15);
        rows.insert(rows.size(), rw);
        // Unseen value in every class: zero sum.
        rw.smp = make_sample(MODE_PROBS, 1'b0, 3'd0, 4'd9);
        rows.insert(rows.size(), rw);
        rw.smp = make_sample(MODE_PREDICT, 1'b1, 3'd0, 4'd9);
        rows.insert(rows.size(), rw);
        rw.smp = make_sample(MODE_PROBS, 1'b1, 3'd0, 4'd15);
        rows.insert(rows.size(), rw);
        rw.smp = make_sample(MODE_TRAIN, 1'b1, 3'd3, 4'd5);
        rows.insert(rows.size(), rw);
        rw.smp = make_sample(MODE_PROBS, 1'b0, 3'd0, 4'd5);
        rows.insert(rows.size(), rw);
        // Clear empties the model again.
        rw.smp = make_sample(MODE_CLEAR, 1'b1, 3'd7, 4'd15);
        rows.insert(rows.size(), rw);
        rw.has_fixed = 1;
        rw.fixed = nm;
        rw.smp = make_sample(MODE_PROBS, 1'b1, 3'd0, 4'd5);
        rows.insert(rows.size(), rw);

        foreach (rows[i])
        begin
            send_sample(rows[i].smp);
            if (rows[i].has_fixed)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("directed row %0d: no verdict queued", i);
                    errors++;
                end
                else
                begin
                    got = verdict_q[$];
                    if (got != rows[i].fixed)
                    begin
                        $error("directed row %0d: predictor disagrees with table", i);
                        errors++;
                    end
                end
            end
        end
        drain();

        // Train every class to build up the counts.
        for (int i = 0; i < 40; i++)
            send_sample(make_sample(MODE_TRAIN, 1'b0, 3'(i % 8), 4'(i % 2)));

        // Receiver hold-off while the sender keeps offering.
        hold_off_cycles <= 8000;
        for (int i = 0; i < 6; i++)
            send_sample(make_sample(MODE_PROBS, 1'b1, 3'd0, 4'(i % 2)));
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 81 : 0;
            recv_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 23 : 0;
            for (int i = 0; i < 85; i++)
                send_sample(random_sample(45));
            // Sender pauses until all results are back.
            drain();
        end
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 12; i++)
            send_sample(make_sample(MODE_TRAIN, 1'b0, 3'($urandom_range(7)),
                                    4'($urandom_range(15))));
        drain();

        if (errors == 0)
            $display("PASS categorical_naive_bayes_classifier_unit");
        else
            $display("FAIL categorical_naive_bayes_classifier_unit");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #80000000;
        $display("FAIL categorical_naive_bayes_classifier_unit");
        $finish;
    end

endmodule
